@@ hw/rtl/circle_pair_collision_test_unit_defines.svh @@
// Assertion macros for the checker file of the collision test unit.
`ifndef CIRCLE_PAIR_COLLISION_TEST_UNIT_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ccd_pkg.sv @@
// Package with the shared types and constants of the collision test unit.
`timescale 1ns / 1ps
package ccd_pkg;
	localparam int MAG_W = 32;
	localparam int SQ_W = 64;
	localparam int SQRT_STAGES = 32;
	localparam logic [1:0] KIND_CIRCLE = 2'd0;

	typedef struct packed {
		logic hit;
		logic neg_x;
		logic neg_y;
		logic [MAG_W-1:0] mx;
		logic [MAG_W-1:0] my;
		logic [MAG_W-1:0] rsum;
	} pair_side_t;
endpackage

@@ hw/rtl/ccd_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module ccd_sqrt
	import ccd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [SQ_W-1:0]  in_x,
	input  pair_side_t       in_side,
	output logic             out_vld,
	output logic [MAG_W-1:0] out_root,
	output pair_side_t       out_side
);
	logic             vld_s  [0:SQRT_STAGES-1];
	logic [SQ_W-1:0]  rem_s  [0:SQRT_STAGES-1];
	logic [SQ_W-1:0]  root_s [0:SQRT_STAGES-1];
	pair_side_t       side_s [0:SQRT_STAGES-1];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
		logic             cur_vld;
		logic [SQ_W-1:0]  cur_rem;
		logic [SQ_W-1:0]  cur_root;
		pair_side_t       cur_side;
		logic [SQ_W-1:0]  trial;

		if (g == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rem  = in_x;
			assign cur_root = '0;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld  = vld_s[g-1];
			assign cur_rem  = rem_s[g-1];
			assign cur_root = root_s[g-1];
			assign cur_side = side_s[g-1];
		end

		assign trial = cur_root + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= cur_side;
				if (cur_rem >= trial) begin
					rem_s[g]  <= cur_rem - trial;
					root_s[g] <= (cur_root >> 1) + BIT;
				end else begin
					rem_s[g]  <= cur_rem;
					root_s[g] <= cur_root >> 1;
				end
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES-1];
	assign out_root = root_s[SQRT_STAGES-1][MAG_W-1:0];
	assign out_side = side_s[SQRT_STAGES-1];
endmodule

@@ hw/rtl/ccd_div.sv @@
// Pipelined restoring divider for both normal components, one quotient bit per stage.
`timescale 1ns / 1ps
module ccd_div
	import ccd_pkg::*;
#(
	parameter int FRAC = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [MAG_W-1:0] in_dist,
	input  pair_side_t       in_side,
	output logic             out_vld,
	output logic [FRAC:0]    out_qx,
	output logic [FRAC:0]    out_qy,
	output logic [MAG_W-1:0] out_dist,
	output pair_side_t       out_side
);
	localparam int NUM_W = MAG_W + FRAC + 1;
	localparam int STAGES = FRAC + 1;

	logic             vld_s  [0:STAGES-1];
	logic [NUM_W-1:0] remx_s [0:STAGES-1];
	logic [NUM_W-1:0] remy_s [0:STAGES-1];
	logic [FRAC:0]    qx_s   [0:STAGES-1];
	logic [FRAC:0]    qy_s   [0:STAGES-1];
	logic [MAG_W-1:0] dist_s [0:STAGES-1];
	pair_side_t       side_s [0:STAGES-1];

	logic [NUM_W-1:0] half;
	logic [NUM_W-1:0] numx;
	logic [NUM_W-1:0] numy;

	assign half = NUM_W'(in_dist >> 1);
	assign numx = ({1'b0, in_side.mx, {FRAC{1'b0}}}) + half;
	assign numy = ({1'b0, in_side.my, {FRAC{1'b0}}}) + half;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		localparam int SH = FRAC - g;
		logic             cur_vld;
		logic [NUM_W-1:0] cur_rx;
		logic [NUM_W-1:0] cur_ry;
		logic [FRAC:0]    cur_qx;
		logic [FRAC:0]    cur_qy;
		logic [MAG_W-1:0] cur_dist;
		pair_side_t       cur_side;
		logic [NUM_W-1:0] dsh;
		logic             bx;
		logic             by;

		if (g == 0) begin : g_first
			assign cur_vld  = in_vld;
			assign cur_rx   = numx;
			assign cur_ry   = numy;
			assign cur_qx   = '0;
			assign cur_qy   = '0;
			assign cur_dist = in_dist;
			assign cur_side = in_side;
		end else begin : g_next
			assign cur_vld  = vld_s[g-1];
			assign cur_rx   = remx_s[g-1];
			assign cur_ry   = remy_s[g-1];
			assign cur_qx   = qx_s[g-1];
			assign cur_qy   = qy_s[g-1];
			assign cur_dist = dist_s[g-1];
			assign cur_side = side_s[g-1];
		end

		assign dsh = {{(FRAC+1){1'b0}}, cur_dist} << SH;
		assign bx  = (cur_rx >= dsh);
		assign by  = (cur_ry >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_s[g] <= bx ? cur_rx - dsh : cur_rx;
				remy_s[g] <= by ? cur_ry - dsh : cur_ry;
				qx_s[g]   <= {cur_qx[FRAC-1:0], bx};
				qy_s[g]   <= {cur_qy[FRAC-1:0], by};
				dist_s[g] <= cur_dist;
				side_s[g] <= cur_side;
			end
		end
	end

	assign out_vld  = vld_s[STAGES-1];
	assign out_qx   = qx_s[STAGES-1];
	assign out_qy   = qy_s[STAGES-1];
	assign out_dist = dist_s[STAGES-1];
	assign out_side = side_s[STAGES-1];
endmodule

@@ hw/rtl/circle_pair_collision_test_unit.sv @@
// Top level of the pipelined circle-circle collision test unit.
// Usage:
// An item on the s_ channel carries the centers and radii of bodies A and B
// in s_tdata and their shape kinds in s_tuser. Each item yields exactly one
// item on the m_ channel with the hit flag in m_tuser and the contact normal
// and penetration depth in m_tdata.
// A new item is taken in every cycle while the output is not stalled. An item
// passes through four setup stages, a 32-stage square root, a divider of
// NORMAL_FRAC_BITS + 1 stages and the output register on its way to m_tvalid.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops; no item is lost or repeated.
`timescale 1ns / 1ps
module circle_pair_collision_test_unit
	import ccd_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int NORMAL_FRAC_BITS = 16,
	localparam int IN_W = ((4 * COORD_WIDTH + 62 + 7) / 8) * 8,
	localparam int NRM_W = NORMAL_FRAC_BITS + 2,
	localparam int OUT_W = ((2 * NRM_W + 32 + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// pos_ax, pos_ay, pos_bx, pos_by, radius_a, radius_b, zero fill
	input  logic [IN_W-1:0] s_tdata,
	// kind_a, kind_b
	input  logic [3:0]      s_tuser,
	output logic            m_tvalid,
	input  logic            m_tready,
	// normal_x, normal_y, penetration, zero fill
	output logic [OUT_W-1:0] m_tdata,
	// hit
	output logic [0:0]       m_tuser
);
	localparam int CW = COORD_WIDTH;
	localparam int F = NORMAL_FRAC_BITS;
	localparam int DW = CW + 1;
	localparam int EW = DW + MAG_W;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic en;
	logic signed [CW-1:0] pax, pay, pbx, pby;
	logic [30:0] ra, rb;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	assign pax = s_tdata[CW-1:0];
	assign pay = s_tdata[2*CW-1:CW];
	assign pbx = s_tdata[3*CW-1:2*CW];
	assign pby = s_tdata[4*CW-1:3*CW];
	assign ra  = s_tdata[4*CW+30:4*CW];
	assign rb  = s_tdata[4*CW+61:4*CW+31];

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [MAG_W-1:0]     rsum_s1, rsum_s2, rsum_s3;
	logic                 ok_s1, ok_s2, ok_s3;
	logic                 negx_s2, negy_s2, negx_s3, negy_s3;
	logic [MAG_W-1:0]     mx_s2, my_s2, mx_s3, my_s3;
	logic [SQ_W-1:0]      sx_s3, sy_s3, rsq_s3, d2_s4;
	pair_side_t           side_s4;

	logic [DW-1:0] magx, magy;
	logic [EW-1:0] emx, emy, ers;
	logic [SQ_W:0] sum2;

	assign magx = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign magy = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
	assign emx  = {{MAG_W{1'b0}}, magx};
	assign emy  = {{MAG_W{1'b0}}, magy};
	assign ers  = {{DW{1'b0}}, rsum_s1};
	assign sum2 = {1'b0, sx_s3} + {1'b0, sy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DW'(pax) - DW'(pbx);
			dy_s1   <= DW'(pay) - DW'(pby);
			rsum_s1 <= MAG_W'(ra) + MAG_W'(rb);
			ok_s1   <= (s_tuser[1:0] == KIND_CIRCLE) && (s_tuser[3:2] == KIND_CIRCLE);

			negx_s2 <= dx_s1[DW-1];
			negy_s2 <= dy_s1[DW-1];
			mx_s2   <= emx[MAG_W-1:0];
			my_s2   <= emy[MAG_W-1:0];
			rsum_s2 <= rsum_s1;
			ok_s2   <= ok_s1 && (emx <= ers) && (emy <= ers);

			sx_s3   <= SQ_W'(mx_s2) * SQ_W'(mx_s2);
			sy_s3   <= SQ_W'(my_s2) * SQ_W'(my_s2);
			rsq_s3  <= SQ_W'(rsum_s2) * SQ_W'(rsum_s2);
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			mx_s3   <= mx_s2;
			my_s3   <= my_s2;
			rsum_s3 <= rsum_s2;
			ok_s3   <= ok_s2;

			d2_s4         <= sum2[SQ_W-1:0];
			side_s4.hit   <= ok_s3 && !sum2[SQ_W] && (sum2[SQ_W-1:0] <= rsq_s3);
			side_s4.neg_x <= negx_s3;
			side_s4.neg_y <= negy_s3;
			side_s4.mx    <= mx_s3;
			side_s4.my    <= my_s3;
			side_s4.rsum  <= rsum_s3;
		end
	end

	logic             sq_vld;
	logic [MAG_W-1:0] sq_root;
	pair_side_t       sq_side;

	ccd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_x     (d2_s4),
		.in_side  (side_s4),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	logic             dv_vld;
	logic [F:0]       dv_qx, dv_qy;
	logic [MAG_W-1:0] dv_dist;
	pair_side_t       dv_side;

	ccd_div #(
		.FRAC (F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.in_dist  (sq_root),
		.in_side  (sq_side),
		.out_vld  (dv_vld),
		.out_qx   (dv_qx),
		.out_qy   (dv_qy),
		.out_dist (dv_dist),
		.out_side (dv_side)
	);

	logic [F:0]       cqx, cqy;
	logic [NRM_W-1:0] nx, ny;
	logic [MAG_W-1:0] pen;

	assign cqx = (dv_qx > ONE) ? ONE : dv_qx;
	assign cqy = (dv_qy > ONE) ? ONE : dv_qy;

	always_comb begin
		nx  = '0;
		ny  = '0;
		pen = '0;
		if (dv_side.hit) begin
			pen = dv_side.rsum - dv_dist;
			if (dv_dist == '0) begin
				ny = -{1'b0, ONE};
			end else begin
				nx = dv_side.neg_x ? -{1'b0, cqx} : {1'b0, cqx};
				ny = dv_side.neg_y ? -{1'b0, cqy} : {1'b0, cqy};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_W'({pen, ny, nx});
			m_tuser <= dv_side.hit;
		end
	end
endmodule

@@ hw/rtl/ccd_checker.sv @@
// Port-level checker for the collision test unit and its bind statement.
`timescale 1ns / 1ps
`include "circle_pair_collision_test_unit_defines.svh"
module ccd_checker #(
	parameter int IN_W = 192,
	parameter int NRM_W = 18,
	parameter int OUT_W = 72
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic [3:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [0:0]       m_tuser
);
	`CCD_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result changed.")
	`CCD_ASSERT_IMP(a_ready, !m_tvalid, s_tready, "Input stalled with an empty output.")
	`CCD_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "A miss carries nonzero fields.")
	`CCD_ASSERT_IMP(a_hit_normal, m_tvalid && m_tuser[0], (m_tdata[NRM_W-1:0] != '0) || (m_tdata[2*NRM_W-1:NRM_W] != '0), "A hit carries a zero normal.")
endmodule

bind circle_pair_collision_test_unit ccd_checker #(
	.IN_W  (IN_W),
	.NRM_W (NRM_W),
	.OUT_W (OUT_W)
) u_ccd_checker (.*);

@@ tb/sv/tb_circle_pair_collision_test_unit.sv @@
// Self-checking testbench for the circle pair collision test unit.
`timescale 1ns / 1ps
module tb_circle_pair_collision_test_unit;
	import ccd_pkg::*;

	localparam int IN_W = 192;
	localparam int OUT_W = 72;
	localparam int LATENCY = 54;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam logic [1:0] KIND_BOX = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	typedef struct {
		logic signed [31:0] ax, ay, bx, by;
		logic [30:0] ra, rb;
		logic [1:0] ka, kb;
	} pair_t;

	typedef struct {
		logic hit;
		logic [17:0] nx, ny;
		logic [31:0] pen;
	} contact_t;

	class contact_scoreboard;
		contact_t pending_contacts[$];
		int errors = 0;

		function automatic bit [63:0] isqrt64(bit [63:0] x);
			bit [63:0] rem, root, b;
			rem = x;
			root = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (rem >= root + b) begin
					rem = rem - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function automatic logic [17:0] normal_comp(bit [63:0] mag, bit neg, bit [63:0] dist_len);
			bit [63:0] q;
			q = (mag * 64'd65536 + dist_len / 2) / dist_len;
			if (q > 64'd65536) q = 64'd65536;
			if (neg) q = -q;
			return q[17:0];
		endfunction

		function automatic contact_t predict_contact(pair_t p);
			contact_t c;
			longint dx, dy;
			bit [63:0] mx, my, rsum, dist_len, pen;
			bit [64:0] d2;
			c = '{hit: 1'b0, nx: '0, ny: '0, pen: '0};
			dx = longint'(p.ax) - longint'(p.bx);
			dy = longint'(p.ay) - longint'(p.by);
			mx = dx < 0 ? -dx : dx;
			my = dy < 0 ? -dy : dy;
			rsum = 64'(p.ra) + 64'(p.rb);
			if (p.ka != KIND_CIRCLE || p.kb != KIND_CIRCLE) return c;
			if (mx > rsum || my > rsum) return c;
			d2 = 65'(mx * mx) + 65'(my * my);
			if (d2 > 65'(rsum * rsum)) return c;
			dist_len = isqrt64(d2[63:0]);
			c.hit = 1'b1;
			if (dist_len == 0) begin
				c.ny = -18'sd65536;
			end else begin
				c.nx = normal_comp(mx, dx < 0, dist_len);
				c.ny = normal_comp(my, dy < 0, dist_len);
			end
			pen = rsum >= dist_len ? rsum - dist_len : 64'd0;
			c.pen = pen > 64'hFFFFFFFF ? 32'hFFFFFFFF : pen[31:0];
			return c;
		endfunction

		function void note_pair(pair_t p);
			pending_contacts.push_back(predict_contact(p));
		endfunction

		function void check_contact(contact_t got);
			contact_t exp_c;
			if (pending_contacts.size() == 0) begin
				$error("unexpected result item");
				errors++;
				return;
			end
			exp_c = pending_contacts.pop_front();
			if (got.hit !== exp_c.hit) begin
				$error("hit: expected %0h, got %0h", exp_c.hit, got.hit);
				errors++;
			end
			if (got.nx !== exp_c.nx) begin
				$error("normal_x: expected %0h, got %0h", exp_c.nx, got.nx);
				errors++;
			end
			if (got.ny !== exp_c.ny) begin
				$error("normal_y: expected %0h, got %0h", exp_c.ny, got.ny);
				errors++;
			end
			if (got.pen !== exp_c.pen) begin
				$error("penetration: expected %0h, got %0h", exp_c.pen, got.pen);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [3:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	contact_scoreboard sb = new();
	int tx_idle = 36;
	int rx_idle = 78;
	int holdoff = 0;
	int cycles = 0;

	circle_pair_collision_test_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (holdoff > 0) begin
			holdoff <= holdoff - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_contact('{hit: m_tuser[0], nx: m_tdata[17:0], ny: m_tdata[35:18],
				pen: m_tdata[67:36]});
	end

	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b0, p.rb, p.ra, p.by, p.bx, p.ay, p.ax};
		s_tuser <= {p.kb, p.ka};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pair(p);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_contacts.size() != 0) @(negedge clk);
	endtask

	function automatic pair_t near_pair();
		pair_t p;
		bit [63:0] rsum, ox, oy;
		p.ka = KIND_CIRCLE;
		p.kb = KIND_CIRCLE;
		if ($urandom_range(9) == 0) begin
			p.ra = 31'($urandom);
			p.rb = 31'($urandom);
		end else begin
			p.ra = 31'($urandom_range(0, 1 << 22));
			p.rb = 31'($urandom_range(0, 1 << 22));
		end
		rsum = 64'(p.ra) + 64'(p.rb);
		ox = rsum * $urandom_range(0, 1000) / 1000;
		oy = rsum * $urandom_range(0, 1000) / 1000;
		p.ax = $urandom;
		p.ay = $urandom;
		p.bx = $urandom_range(1) ? p.ax - 32'(ox) : p.ax + 32'(ox);
		p.by = $urandom_range(1) ? p.ay - 32'(oy) : p.ay + 32'(oy);
		return p;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int sel;
		sel = $urandom_range(99);
		p = near_pair();
		if (sel >= 70 && sel < 85) begin
			p.ax = $urandom;
			p.ay = $urandom;
			p.bx = $urandom;
			p.by = $urandom;
			p.ra = 31'($urandom);
			p.rb = 31'($urandom);
			p.ka = 2'($urandom_range(3));
			p.kb = 2'($urandom_range(3));
		end else if (sel >= 85) begin
			p.ka = 2'($urandom_range(3));
			p.kb = 2'($urandom_range(1, 3));
			if ($urandom_range(1)) begin
				p.ka = p.kb;
				p.kb = KIND_CIRCLE;
			end
		end
		return p;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_pair(random_pair());
	endtask

	initial begin
		pair_t p;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Coincident centers, touching exactly, and just apart.
		send_pair('{32'sd100, 32'sd200, 32'sd100, 32'sd200, 31'd5, 31'd7, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd30, 32'sd0, 32'sd0, 32'sd0, 31'd10, 31'd20, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd0, -32'sd30, 32'sd0, 32'sd0, 31'd10, 31'd20, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd31, 32'sd0, 32'sd0, 32'sd0, 31'd10, 31'd20, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd3, 32'sd4, 32'sd0, 32'sd0, 31'd2, 31'd3, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{-32'sd3, -32'sd4, 32'sd0, 32'sd0, 31'd2, 31'd3, KIND_CIRCLE, KIND_CIRCLE});
		// Unsupported kinds on an overlapping pair.
		send_pair('{32'sd0, 32'sd0, 32'sd1, 32'sd1, 31'd100, 31'd100, KIND_BOX, KIND_CIRCLE});
		send_pair('{32'sd0, 32'sd0, 32'sd1, 32'sd1, 31'd100, 31'd100, KIND_CIRCLE, KIND_OTHER});
		send_pair('{32'sd0, 32'sd0, 32'sd1, 32'sd1, 31'd100, 31'd100, KIND_OTHER, KIND_OTHER});
		// Coordinate and radius extremes, including the largest separations, then near-touching pairs.
		p = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			31'h7FFFFFFF, 31'h7FFFFFFF, KIND_CIRCLE, KIND_CIRCLE};
		send_pair(p);
		p.ay = 32'sd0;
		p.by = 32'sd0;
		send_pair(p);
		p = '{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			31'h7FFFFFFF, 31'h0, KIND_CIRCLE, KIND_CIRCLE};
		send_pair(p);
		send_pair('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			31'h7FFFFFFF, 31'h7FFFFFFF, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0,
			31'd1, 31'd1, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd65536, 32'sd65536, 32'sd0, 32'sd0,
			31'd65536, 31'd27146, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd1, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd1, KIND_CIRCLE, KIND_CIRCLE});
		send_pair('{32'sd0, 32'sd1, 32'sd0, 32'sd0, 31'd1, 31'd0, KIND_CIRCLE, KIND_CIRCLE});

		run_random(180);
		drain();
		tx_idle = 78;
		rx_idle = 36;
		run_random(180);
		drain();
		tx_idle = 0;
		rx_idle = 0;
		holdoff = HOLDOFF_CYCLES;
		run_random(180);
		s_tvalid <= 1'b0;

		while (sb.pending_contacts.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_contacts.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
